// ----- src/spectral_noise_subtraction_core_defines.svh -----
// assertion macros for the spectral noise subtraction core
`ifndef SPECTRAL_NOISE_SUBTRACTION_CORE_DEFINES_SVH
`define SPECTRAL_NOISE_SUBTRACTION_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SNC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/snc_pkg.sv -----
// types, stage map and arithmetic step functions of the noise subtraction core
package snc_pkg;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 64;
  localparam int MEM_W       = 80;

  localparam logic ACT_TRAIN = 1'b0;
  localparam logic ACT_APPLY = 1'b1;

  localparam logic [15:0] GAIN_RESET = 16'd640;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;
  localparam logic [47:0] MAX48      = 48'hFFFF_FFFF_FFFF;

  // stage map of the item line
  localparam int ST_S0   = 0;
  localparam int ST_S1   = 1;
  localparam int ST_S2   = 2;
  localparam int ST_QB   = 3;
  localparam int SQ_N    = 32;
  localparam int ST_R    = ST_QB + SQ_N;
  localparam int ST_DB   = ST_R + 1;
  localparam int DT_N    = 48;
  localparam int ST_W    = ST_DB + DT_N;
  localparam int ST_V0   = ST_W + 1;
  localparam int ST_EB   = ST_V0 + 1;
  localparam int DV_N    = 64;
  localparam int ST_F    = ST_EB + DV_N + 1;
  localparam int ST_GB   = ST_F + 1;
  localparam int ST_H0   = ST_GB + SQ_N;
  localparam int ST_H1   = ST_H0 + 1;
  localparam int ST_JB   = ST_H1 + 1;
  localparam int DS_N    = 32;
  localparam int ST_LAST = ST_JB + DS_N;

  typedef struct packed {
    logic        action;
    logic        in_range;
    logic        lt2;
    logic [10:0] idx;
    logic [15:0] n;
    logic [31:0] mre;
    logic [31:0] mim;
    logic        nre;
    logic        nim;
    logic [47:0] sqin;
    logic [31:0] mag;
    logic [31:0] mean;
    logic [47:0] sq;
    logic [47:0] mean2;
    logic        up_m;
    logic        up_s;
  } item_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        q;
  } div_t;

  function automatic sqrt_t sqrt_step(input logic [35:0] rem, input logic [31:0] root,
                                      input logic [1:0] pair);
    logic [35:0] r2;
    logic [35:0] t;
    sqrt_t       res;
    r2 = {rem[33:0], pair};
    t  = {2'b00, root, 2'b01};
    if (r2 >= t) begin
      res.rem  = r2 - t;
      res.root = {root[30:0], 1'b1};
    end else begin
      res.rem  = r2;
      res.root = {root[30:0], 1'b0};
    end
    return res;
  endfunction

  function automatic div_t div_step(input logic [31:0] rem, input logic din,
                                    input logic [31:0] dvs);
    logic [32:0] t;
    logic [32:0] d;
    div_t        res;
    t = {rem, din};
    d = {1'b0, dvs};
    if (t >= d) begin
      res.rem = 32'(t - d);
      res.q   = 1'b1;
    end else begin
      res.rem = t[31:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage

// ----- src/snc_ram.sv -----
// generic simple dual port ram with registered read
module snc_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/spectral_noise_subtraction_core.sv -----
// spectral subtraction noise reducer: per-bin noise profile training and suppression
// train beats give no output beat
// throughput: one beat per cycle unless out_tready stalls the output; a beat waits while an
//   earlier train beat of the same bin has not yet written back its profile
// reset: synchronous; count and gain reset, then a clearing pass over all BLOCK_SIZE entries
//   zeroes the profile ram while in_tready stays low
`include "spectral_noise_subtraction_core_defines.svh"

module spectral_noise_subtraction_core #(
  parameter int BLOCK_SIZE = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [15:0]                        cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // bin_index, bin_real, bin_imag, zero pad
  input  logic [snc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_real, out_imag
  output logic [snc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // too_little_noise
  output logic [0:0]                         out_tuser
);

  import snc_pkg::*;

  localparam int AW = $clog2(BLOCK_SIZE);

  logic            en;
  logic            accept;
  logic            haz;
  logic            clr_busy_r;
  logic [AW-1:0]   clr_addr_r;
  logic [15:0]     cnt_r;
  logic [15:0]     cnt_nxt;
  logic [15:0]     gain_r;

  logic [10:0]     in_idx;
  logic [31:0]     in_re;
  logic [31:0]     in_im;
  logic            in_act;
  logic            in_rng;

  item_t           itp_r   [0:ST_LAST];
  item_t           itp_nxt [0:ST_LAST];
  logic            vld_r   [0:ST_LAST];

  logic [63:0]     prod_re_r, prod_im_r, prod_re_nxt, prod_im_nxt;
  logic [63:0]     sumsq_r;

  logic [63:0]     q_rad_r  [0:SQ_N-1];
  logic [35:0]     q_rem_r  [0:SQ_N-1];
  logic [31:0]     q_root_r [0:SQ_N-1];
  logic [63:0]     q_rad_nxt  [0:SQ_N-1];
  sqrt_t           q_st_nxt   [0:SQ_N-1];

  logic [47:0]     dm_num_r [0:DT_N];
  logic [31:0]     dm_rem_r [0:DT_N];
  logic [47:0]     ds_num_r [0:DT_N];
  logic [31:0]     ds_rem_r [0:DT_N];
  logic [47:0]     dm_num_nxt [0:DT_N];
  logic [31:0]     dm_rem_nxt [0:DT_N];
  logic [47:0]     ds_num_nxt [0:DT_N];
  logic [31:0]     ds_rem_nxt [0:DT_N];

  logic [47:0]     v_diff_r, v_diff_nxt;

  logic [63:0]     e_num_r [0:DV_N];
  logic [31:0]     e_rem_r [0:DV_N];
  logic [63:0]     e_num_nxt [0:DV_N];
  logic [31:0]     e_rem_nxt [0:DV_N];

  logic [47:0]     var_r, var_nxt;

  logic [63:0]     g_rad_r  [0:SQ_N-1];
  logic [35:0]     g_rem_r  [0:SQ_N-1];
  logic [31:0]     g_root_r [0:SQ_N-1];
  logic [63:0]     g_rad_nxt  [0:SQ_N-1];
  sqrt_t           g_st_nxt   [0:SQ_N-1];

  logic [47:0]     gm_r, gm_nxt;
  logic [31:0]     num_r, num_nxt;
  logic [40:0]     noise;

  logic [31:0]     jr_num_r [0:DS_N];
  logic [31:0]     jr_rem_r [0:DS_N];
  logic [31:0]     ji_num_r [0:DS_N];
  logic [31:0]     ji_rem_r [0:DS_N];
  logic [31:0]     jr_num_nxt [0:DS_N];
  logic [31:0]     jr_rem_nxt [0:DS_N];
  logic [31:0]     ji_num_nxt [0:DS_N];
  logic [31:0]     ji_rem_nxt [0:DS_N];
  logic [63:0]     pr_re, pr_im;

  logic [MEM_W-1:0] ram_q;
  logic [31:0]      ram_m;
  logic [47:0]      ram_s;
  logic [63:0]      msq;
  logic [31:0]      r_mag;
  logic [47:0]      r_sq;
  logic             wr_train;
  logic [31:0]      new_m;
  logic [47:0]      new_s;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [MEM_W-1:0] ram_wdata;

  logic             out_valid_r;
  logic [31:0]      out_real_r, out_imag_r;
  logic             out_flag_r;
  logic [31:0]      fin_re, fin_im;
  logic             fin_zero;

  assign en     = !out_valid_r || out_tready;
  assign in_idx = in_tdata[10:0];
  assign in_re  = in_tdata[42:11];
  assign in_im  = in_tdata[74:43];
  assign in_act = in_tuser[0];
  assign in_rng = 32'(in_idx) < BLOCK_SIZE;

  // pending train writes to the same bin
  always_comb begin
    haz = 1'b0;
    for (int k = 0; k <= ST_W; k++) begin
      if (vld_r[k] && itp_r[k].action == ACT_TRAIN && itp_r[k].in_range &&
          itp_r[k].idx == in_idx) begin
        haz = 1'b1;
      end
    end
  end

  assign in_tready = en && !clr_busy_r && !haz;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_act == ACT_TRAIN && in_idx == 11'd0 && in_rng && cnt_r != CNT_MAX) begin
      cnt_nxt = cnt_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      gain_r     <= GAIN_RESET;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(BLOCK_SIZE - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // item line
  always_comb begin
    itp_nxt[0]          = '0;
    itp_nxt[0].action   = in_act;
    itp_nxt[0].in_range = in_rng;
    itp_nxt[0].idx      = in_idx;
    itp_nxt[0].lt2      = cnt_r < 16'd2;
    if (in_act == ACT_TRAIN) begin
      itp_nxt[0].n = (cnt_nxt == 16'd0) ? 16'd1 : cnt_nxt;
    end else begin
      itp_nxt[0].n = cnt_r;
    end
    itp_nxt[0].nre = in_re[31];
    itp_nxt[0].nim = in_im[31];
    itp_nxt[0].mre = in_re[31] ? (~in_re + 32'd1) : in_re;
    itp_nxt[0].mim = in_im[31] ? (~in_im + 32'd1) : in_im;
    for (int k = 1; k <= ST_LAST; k++) begin
      itp_nxt[k] = itp_r[k-1];
    end
    itp_nxt[ST_QB].sqin = sumsq_r[63:16];
    itp_nxt[ST_R].mag   = q_root_r[SQ_N-1];
    itp_nxt[ST_DB].mean  = ram_m;
    itp_nxt[ST_DB].sq    = ram_s;
    itp_nxt[ST_DB].mean2 = msq[63:16];
    itp_nxt[ST_DB].up_m  = r_mag >= ram_m;
    itp_nxt[ST_DB].up_s  = r_sq >= ram_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ST_LAST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= accept;
      for (int k = 1; k <= ST_LAST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= ST_LAST; k++) begin
        itp_r[k] <= itp_nxt[k];
      end
    end
  end

  // squares and magnitude sqrt
  assign prod_re_nxt = itp_r[ST_S0].mre * itp_r[ST_S0].mre;
  assign prod_im_nxt = itp_r[ST_S0].mim * itp_r[ST_S0].mim;

  always_comb begin
    for (int i = 0; i < SQ_N; i++) begin
      if (i == 0) begin
        q_st_nxt[i]  = sqrt_step(36'd0, 32'd0, sumsq_r[63:62]);
        q_rad_nxt[i] = {sumsq_r[61:0], 2'b00};
      end else begin
        q_st_nxt[i]  = sqrt_step(q_rem_r[i-1], q_root_r[i-1], q_rad_r[i-1][63:62]);
        q_rad_nxt[i] = {q_rad_r[i-1][61:0], 2'b00};
      end
    end
  end

  // profile update divides
  assign ram_m = ram_q[31:0];
  assign ram_s = ram_q[79:32];
  assign msq   = ram_m * ram_m;
  assign r_mag = itp_r[ST_R].mag;
  assign r_sq  = itp_r[ST_R].sqin;

  always_comb begin
    dm_num_nxt[0] = 48'(r_mag >= ram_m ? r_mag - ram_m : ram_m - r_mag);
    ds_num_nxt[0] = r_sq >= ram_s ? r_sq - ram_s : ram_s - r_sq;
    dm_rem_nxt[0] = '0;
    ds_rem_nxt[0] = '0;
    for (int j = 1; j <= DT_N; j++) begin
      div_t sm;
      div_t ss;
      sm = div_step(dm_rem_r[j-1], dm_num_r[j-1][47], {16'd0, itp_r[ST_DB+j-1].n});
      ss = div_step(ds_rem_r[j-1], ds_num_r[j-1][47], {16'd0, itp_r[ST_DB+j-1].n});
      dm_rem_nxt[j] = sm.rem;
      dm_num_nxt[j] = {dm_num_r[j-1][46:0], sm.q};
      ds_rem_nxt[j] = ss.rem;
      ds_num_nxt[j] = {ds_num_r[j-1][46:0], ss.q};
    end
  end

  assign new_m = itp_r[ST_W].up_m ? itp_r[ST_W].mean + dm_num_r[DT_N][31:0]
                                  : itp_r[ST_W].mean - dm_num_r[DT_N][31:0];
  assign new_s = itp_r[ST_W].up_s ? itp_r[ST_W].sq + ds_num_r[DT_N]
                                  : itp_r[ST_W].sq - ds_num_r[DT_N];
  assign wr_train = vld_r[ST_W] && itp_r[ST_W].action == ACT_TRAIN && itp_r[ST_W].in_range;

  assign ram_we    = clr_busy_r || wr_train;
  assign ram_waddr = clr_busy_r ? clr_addr_r : AW'(itp_r[ST_W].idx);
  assign ram_wdata = clr_busy_r ? '0 : {new_s, new_m};

  snc_ram #(
    .WIDTH (MEM_W),
    .DEPTH (BLOCK_SIZE)
  ) u_profile_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (AW'(itp_r[ST_R-1].idx)),
    .rdata (ram_q)
  );

  // variance and deviation
  assign v_diff_nxt = itp_r[ST_W].sq > itp_r[ST_W].mean2 ?
                      itp_r[ST_W].sq - itp_r[ST_W].mean2 : 48'd0;

  always_comb begin
    e_num_nxt[0] = v_diff_r * itp_r[ST_V0].n;
    e_rem_nxt[0] = '0;
    for (int j = 1; j <= DV_N; j++) begin
      div_t se;
      se = div_step(e_rem_r[j-1], e_num_r[j-1][63],
                    {16'd0, itp_r[ST_EB+j-1].n - 16'd1});
      e_rem_nxt[j] = se.rem;
      e_num_nxt[j] = {e_num_r[j-1][62:0], se.q};
    end
  end

  assign var_nxt = (e_num_r[DV_N][63:48] != 16'd0) ? MAX48 : e_num_r[DV_N][47:0];

  always_comb begin
    for (int i = 0; i < SQ_N; i++) begin
      if (i == 0) begin
        g_st_nxt[i]  = sqrt_step(36'd0, 32'd0, var_r[47:46]);
        g_rad_nxt[i] = {var_r[45:0], 18'd0};
      end else begin
        g_st_nxt[i]  = sqrt_step(g_rem_r[i-1], g_root_r[i-1], g_rad_r[i-1][63:62]);
        g_rad_nxt[i] = {g_rad_r[i-1][61:0], 2'b00};
      end
    end
  end

  // noise estimate and scaling
  assign gm_nxt  = gain_r * g_root_r[SQ_N-1];
  assign noise   = {9'd0, itp_r[ST_H0].mean} + {1'b0, gm_r[47:8]};
  assign num_nxt = ({9'd0, itp_r[ST_H0].mag} > noise) ?
                   itp_r[ST_H0].mag - noise[31:0] : 32'd0;
  assign pr_re   = itp_r[ST_H1].mre * num_r;
  assign pr_im   = itp_r[ST_H1].mim * num_r;

  always_comb begin
    jr_num_nxt[0] = pr_re[31:0];
    jr_rem_nxt[0] = pr_re[63:32];
    ji_num_nxt[0] = pr_im[31:0];
    ji_rem_nxt[0] = pr_im[63:32];
    for (int j = 1; j <= DS_N; j++) begin
      div_t sr;
      div_t si;
      sr = div_step(jr_rem_r[j-1], jr_num_r[j-1][31], itp_r[ST_JB+j-1].mag);
      si = div_step(ji_rem_r[j-1], ji_num_r[j-1][31], itp_r[ST_JB+j-1].mag);
      jr_rem_nxt[j] = sr.rem;
      jr_num_nxt[j] = {jr_num_r[j-1][30:0], sr.q};
      ji_rem_nxt[j] = si.rem;
      ji_num_nxt[j] = {ji_num_r[j-1][30:0], si.q};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_re_r <= prod_re_nxt;
      prod_im_r <= prod_im_nxt;
      sumsq_r   <= prod_re_r + prod_im_r;
      for (int i = 0; i < SQ_N; i++) begin
        q_rad_r[i]  <= q_rad_nxt[i];
        q_rem_r[i]  <= q_st_nxt[i].rem;
        q_root_r[i] <= q_st_nxt[i].root;
        g_rad_r[i]  <= g_rad_nxt[i];
        g_rem_r[i]  <= g_st_nxt[i].rem;
        g_root_r[i] <= g_st_nxt[i].root;
      end
      for (int j = 0; j <= DT_N; j++) begin
        dm_num_r[j] <= dm_num_nxt[j];
        dm_rem_r[j] <= dm_rem_nxt[j];
        ds_num_r[j] <= ds_num_nxt[j];
        ds_rem_r[j] <= ds_rem_nxt[j];
      end
      v_diff_r <= v_diff_nxt;
      for (int j = 0; j <= DV_N; j++) begin
        e_num_r[j] <= e_num_nxt[j];
        e_rem_r[j] <= e_rem_nxt[j];
      end
      var_r <= var_nxt;
      gm_r  <= gm_nxt;
      num_r <= num_nxt;
      for (int j = 0; j <= DS_N; j++) begin
        jr_num_r[j] <= jr_num_nxt[j];
        jr_rem_r[j] <= jr_rem_nxt[j];
        ji_num_r[j] <= ji_num_nxt[j];
        ji_rem_r[j] <= ji_rem_nxt[j];
      end
    end
  end

  // output register
  assign fin_zero = itp_r[ST_LAST].lt2 || !itp_r[ST_LAST].in_range ||
                    itp_r[ST_LAST].mag == 32'd0;
  assign fin_re = itp_r[ST_LAST].nre ? (~jr_num_r[DS_N] + 32'd1) : jr_num_r[DS_N];
  assign fin_im = itp_r[ST_LAST].nim ? (~ji_num_r[DS_N] + 32'd1) : ji_num_r[DS_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[ST_LAST] && itp_r[ST_LAST].action == ACT_APPLY;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flag_r <= itp_r[ST_LAST].lt2;
      out_real_r <= fin_zero ? 32'd0 : fin_re;
      out_imag_r <= fin_zero ? 32'd0 : fin_im;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_imag_r, out_real_r};
  assign out_tuser  = out_flag_r;

  `SNC_ASSERT_SAME(a_no_train_write_in_clear, wr_train, !clr_busy_r, "train write during clear")
  `SNC_ASSERT_NEXT(a_clear_done_stays, !clr_busy_r, !clr_busy_r, "clearing pass restarted")
  `SNC_ASSERT_NEXT(a_count_saturates, cnt_r == CNT_MAX, cnt_r == CNT_MAX, "block count wrapped")
  `SNC_ASSERT_SAME(a_flag_zero_data, out_valid_r && out_flag_r, out_tdata == '0, "flagged nonzero")

endmodule

// ----- tb/tb_spectral_noise_subtraction_core.sv -----
// testbench of the spectral noise subtraction core: directed table and random training/apply runs
`timescale 1ns / 100ps

module tb_spectral_noise_subtraction_core;
  import snc_pkg::*;

  localparam int NBINS     = 2048;
  localparam int SETTLE    = 230;
  localparam int HOLD_LEN  = 400;
  localparam int PER_PHASE = 310;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        few;
  } bin_res_t;

  typedef struct packed {
    logic        action;
    logic [10:0] idx;
    logic [31:0] re;
    logic [31:0] im;
    logic        typed;
    bin_res_t    res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  logic [31:0] prof_mean [NBINS];
  logic [47:0] prof_sq [NBINS];
  logic [15:0] blocks;
  logic [15:0] gain;
  bin_res_t    pending[$];
  int          errors = 0;
  int          accepted = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_left = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;

  spectral_noise_subtraction_core #(.BLOCK_SIZE(NBINS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] step_toward(input logic [63:0] old, input logic [63:0] x,
                                             input logic [63:0] n);
    if (x >= old) return old + (x - old) / n;
    return old - (old - x) / n;
  endfunction

  function automatic logic [31:0] scale_comp(input logic [31:0] v, input logic [63:0] num,
                                            input logic [63:0] den);
    logic [63:0] m;
    logic [63:0] q;
    m = v[31] ? 64'h1_0000_0000 - {32'b0, v} : {32'b0, v};
    q = (m * num) / den;
    if (v[31]) q = 64'd0 - q;
    return q[31:0];
  endfunction

  // updates the noise profile for a train beat, returns 1 with the scaled bin for an apply beat
  function automatic logic suppress_bin(input logic act, input logic [10:0] idx,
                                        input logic [31:0] re, input logic [31:0] im,
                                        output bin_res_t res);
    logic [63:0] mre, mim, sumsq, mag, n, mean, mean2, sq, diff, var_q, dev, noise, num;
    mre = re[31] ? 64'h1_0000_0000 - {32'b0, re} : {32'b0, re};
    mim = im[31] ? 64'h1_0000_0000 - {32'b0, im} : {32'b0, im};
    sumsq = mre * mre + mim * mim;
    mag = int_sqrt(sumsq);
    res = '0;
    if (act == ACT_TRAIN) begin
      if (idx == 0 && blocks != CNT_MAX) blocks = blocks + 1;
      n = (blocks == 0) ? 64'd1 : {48'b0, blocks};
      prof_mean[idx] = 32'(step_toward({32'b0, prof_mean[idx]}, mag, n));
      prof_sq[idx] = 48'(step_toward({16'b0, prof_sq[idx]}, sumsq >> 16, n));
      return 1'b0;
    end
    if (blocks < 2) begin
      res.few = 1'b1;
      return 1'b1;
    end
    if (mag == 0) return 1'b1;
    n = {48'b0, blocks};
    mean = {32'b0, prof_mean[idx]};
    mean2 = (mean * mean) >> 16;
    sq = {16'b0, prof_sq[idx]};
    diff = (sq > mean2) ? sq - mean2 : 64'd0;
    var_q = (diff * n) / (n - 1);
    if (var_q > {16'b0, MAX48}) var_q = {16'b0, MAX48};
    dev = int_sqrt(var_q << 16);
    noise = mean + (({48'b0, gain} * dev) >> 8);
    num = (mag > noise) ? mag - noise : 64'd0;
    res.re = scale_comp(re, num, mag);
    res.im = scale_comp(im, num, mag);
    return 1'b1;
  endfunction

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    bin_res_t got;
    bin_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[31:0], out_tdata[63:32], out_tuser[0]};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat re=%h im=%h flag=%b",
                                   got.re, got.im, got.few);
      end else begin
        want = pending.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected re=%h im=%h flag=%b, got re=%h im=%h flag=%b",
                     want.re, want.im, want.few, got.re, got.im, got.few);
        end
      end
    end
  end

  task automatic send_bin(input stim_row_t row);
    bin_res_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, row.im, row.re, row.idx};
    in_tuser <= row.action;
    do @(posedge clk); while (!in_tready);
    accepted++;
    if (suppress_bin(row.action, row.idx, row.re, row.im, res))
      pending.push_back(row.typed ? row.res : res);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_gain(input logic [15:0] g);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    gain = g;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_part;
    return 32'($signed($urandom()) >>> $urandom_range(0, 31));
  endfunction

  task automatic random_phase(input int target, input bit do_hold, input bit do_pause);
    stim_row_t row;
    int        stop_at;
    int        nbins;
    int        scale;
    stop_at = accepted + target;
    while (accepted < stop_at) begin
      if (do_hold && accepted > stop_at - target / 2) begin
        hold_reqs++;
        do_hold = 1'b0;
      end
      if (do_pause && accepted > stop_at - target / 3) begin
        drain();
        do_pause = 1'b0;
      end
      row = '0;
      if ($urandom_range(0, 9) < 8) begin
        nbins = $urandom_range(3, 16);
        scale = $urandom_range(8, 30);
        repeat ($urandom_range(1, 3)) begin
          for (int b = 0; b < nbins; b++) begin
            row.action = ACT_TRAIN;
            row.idx = 11'(b);
            row.re = 32'($signed($urandom()) >>> scale);
            row.im = 32'($signed($urandom()) >>> scale);
            send_bin(row);
          end
        end
        repeat ($urandom_range(2, 12)) begin
          row.action = ACT_APPLY;
          row.idx = 11'($urandom_range(0, nbins - 1));
          row.re = 32'($signed($urandom()) >>> (scale - $urandom_range(0, 3)));
          row.im = 32'($signed($urandom()) >>> (scale - $urandom_range(0, 3)));
          send_bin(row);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          row.action = 1'($urandom_range(0, 1));
          row.idx = 11'($urandom_range(0, NBINS - 1));
          row.re = rand_part();
          row.im = rand_part();
          send_bin(row);
        end
      end
    end
  endtask

  stim_row_t directed [18] = '{
    '{ACT_APPLY, 11'd5,    32'h0000_0001, 32'h0000_0000, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ACT_TRAIN, 11'd7,    32'h0001_0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_TRAIN, 11'd0,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{ACT_TRAIN, 11'd2047, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{ACT_TRAIN, 11'd5,    32'h0003_0000, 32'hFFFC_0000, 1'b0, '0},
    '{ACT_APPLY, 11'd5,    32'h0003_0000, 32'h0000_0000, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{ACT_TRAIN, 11'd0,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_TRAIN, 11'd5,    32'h0005_0000, 32'h0001_0000, 1'b0, '0},
    '{ACT_TRAIN, 11'd7,    32'h0002_0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_TRAIN, 11'd2047, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{ACT_APPLY, 11'd5,    32'h0000_0000, 32'h0000_0000, 1'b1, '{32'd0, 32'd0, 1'b0}},
    '{ACT_APPLY, 11'd5,    32'h0040_0000, 32'hFFC0_0000, 1'b0, '0},
    '{ACT_APPLY, 11'd7,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{ACT_APPLY, 11'd2047, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{ACT_APPLY, 11'd2047, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{ACT_APPLY, 11'd0,    32'h0000_0001, 32'h0000_0000, 1'b0, '0},
    '{ACT_APPLY, 11'd1024, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0},
    '{ACT_APPLY, 11'd7,    32'h0001_0000, 32'h0000_0000, 1'b0, '0}
  };

  initial begin
    for (int i = 0; i < NBINS; i++) begin
      prof_mean[i] = '0;
      prof_sq[i] = '0;
    end
    blocks = '0;
    gain = GAIN_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_gain(GAIN_RESET);
    foreach (directed[i]) send_bin(directed[i]);
    drain();

    write_gain(16'hFFFF);
    send_idle = 0;
    recv_stall = 0;
    random_phase(PER_PHASE, 1'b1, 1'b0);
    drain();

    write_gain(16'h0000);
    send_idle = 46;
    recv_stall = 0;
    random_phase(PER_PHASE, 1'b0, 1'b1);
    drain();

    write_gain(16'($urandom()));
    send_idle = 0;
    recv_stall = 46;
    random_phase(PER_PHASE, 1'b0, 1'b0);
    drain();

    write_gain(16'd300);
    send_idle = 13;
    recv_stall = 13;
    random_phase(PER_PHASE, 1'b0, 1'b0);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
